>>> design/dvss_pkg.sv
// dvss_pkg: shared types, constants and segment table for the dual value
// seven segment scanner. No dependencies; used by the top level and its checker.

package dvss_pkg;

	localparam int SLOT_W  = 4;
	localparam int SEL_W   = 10;
	localparam int VAL_W   = 15;
	localparam int SEG_W   = 8;
	localparam int GLYPH_W = 6;

	localparam logic [SLOT_W-1:0] SLOT_RED   = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_GREEN = 4'd9;

	localparam logic [GLYPH_W-1:0] GLYPH_NEG = 6'd32;
	localparam logic [SEG_W-1:0]   SEG_BLANK = 8'hff;

	// register indexes, decoded from paddr[2]
	localparam logic REG_BLINK_ENABLE   = 1'b0;
	localparam logic REG_BLINK_POSITION = 1'b1;

	// digit places within one four digit value
	localparam logic [1:0] PLACE_THOU = 2'd0;
	localparam logic [1:0] PLACE_HUN  = 2'd1;
	localparam logic [1:0] PLACE_TEN  = 2'd2;
	localparam logic [1:0] PLACE_UNIT = 2'd3;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              blink;
		logic [SEG_W-1:0]  leds;
	} ctl_t;

	function automatic logic [SEG_W-1:0] seg_lookup(input logic [GLYPH_W-1:0] g);
		logic [SEG_W-1:0] s;
		case (g)
			6'd0:  s = 8'h84;
			6'd1:  s = 8'hf5;
			6'd2:  s = 8'hc2;
			6'd3:  s = 8'hc1;
			6'd4:  s = 8'hb1;
			6'd5:  s = 8'h89;
			6'd6:  s = 8'h88;
			6'd7:  s = 8'he5;
			6'd8:  s = 8'h80;
			6'd9:  s = 8'h81;
			6'd10: s = 8'ha0;
			6'd11: s = 8'h98;
			6'd12: s = 8'h8e;
			6'd13: s = 8'hd0;
			6'd14: s = 8'h8a;
			6'd15: s = 8'haa;
			6'd16: s = 8'h8c;
			6'd17: s = 8'hb0;
			6'd18: s = 8'hd5;
			6'd19: s = 8'ha8;
			6'd20: s = 8'h9e;
			6'd21: s = 8'he8;
			6'd22: s = 8'hf8;
			6'd23: s = 8'hd8;
			6'd24: s = 8'ha2;
			6'd25: s = 8'hfa;
			6'd26: s = 8'h9a;
			6'd27: s = 8'hdc;
			6'd28: s = 8'hcc;
			6'd29: s = 8'h91;
			6'd30: s = 8'hfb;
			6'd31: s = 8'h00;
			6'd32: s = 8'h01;
			6'd33: s = 8'hff;
			6'd34: s = 8'h44;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

>>> design/dual_value_seven_segment_scanner_unit.sv
// Multiplexed seven segment scanner, top level: slot counter, digit split
// pipeline, segment lookup and APB register bank. Depends on dvss_pkg.

// One beat in gives one beat out: the segment byte and one-hot common select
// for the current refresh slot. Slots 0 to 3 show upper_value and 4 to 7 show
// lower_value as four decimal digits each, thousands first; a negative value
// shows its magnitude mod 1000 with a minus glyph in the thousands place.
// Slot 8 drives red_leds, slot 9 green_leds, and slots 10 and up (when
// NUM_SLOTS exceeds 10) are blank with no common selected. The slot counter
// advances on every accepted beat and wraps at NUM_SLOTS. A new beat is taken
// every cycle while the output is not stalled; each beat passes through the
// constant divide chain (seven pipeline stages and the output register), and
// the whole pipeline holds only while a result waits at the output. blink_enable
// and blink_position are APB registers at byte addresses 0 and 4.

module dual_value_seven_segment_scanner_unit
	import dvss_pkg::*;
#(
	parameter int NUM_SLOTS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VAL_W-1:0] upper_value,
	input  logic signed [VAL_W-1:0] lower_value,
	input  logic [SEG_W-1:0]        red_leds,
	input  logic [SEG_W-1:0]        green_leds,
	input  logic                    blink_phase,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SEG_W-1:0]        segments,
	output logic [SEL_W-1:0]        common_select
);

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

	logic              blink_enable_q;
	logic [2:0]        blink_position_q;
	logic [SLOT_W-1:0] slot_q;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;

	logic signed [VAL_W-1:0] val_s1;
	logic                    neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [VAL_W-1:0]        mag_s2, mag_s3;
	logic [4:0]              thou_s3, thou_s4, thou_s5, thou_s6, thou_s7;
	logic [9:0]              rem_s4, rem_s5;
	logic [3:0]              hun_s5, hun_s6, hun_s7;
	logic [6:0]              tr_s6, tr_s7;
	logic [3:0]              ten_s7;

	logic [30:0]       thou_prod;
	logic [VAL_W-1:0]  rem_full;
	logic [15:0]       hun_prod;
	logic [9:0]        tr_full;
	logic [14:0]       ten_prod;
	logic [6:0]        unit_full;
	logic [3:0]        unit_d;
	logic [GLYPH_W-1:0] glyph_d;
	logic [SEG_W-1:0]  seg_d;
	logic [SEL_W-1:0]  sel_d;

	// apb register bank
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_enable_q   <= 1'b0;
			blink_position_q <= 3'd0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_BLINK_ENABLE:   blink_enable_q   <= pwdata[0];
				REG_BLINK_POSITION: blink_position_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BLINK_ENABLE:   prdata = {31'd0, blink_enable_q};
			REG_BLINK_POSITION: prdata = {29'd0, blink_position_q};
			default:            prdata = 32'd0;
		endcase
	end

	// pipeline moves whenever the output register can take a beat
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (in_valid && in_ready) begin
			slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			out_valid <= v_s7;
		end
	end

	// constant divides by reciprocal multiply
	assign thou_prod = 31'(mag_s3) * 31'd33555;
	assign rem_full  = mag_s3 - VAL_W'(thou_s3) * VAL_W'(1000);
	assign hun_prod  = 16'(rem_s4) * 16'd41;
	assign tr_full   = rem_s5 - 10'(hun_s5) * 10'd100;
	assign ten_prod  = 15'(tr_s6) * 15'd205;
	assign unit_full = tr_s7 - 7'(ten_s7) * 7'd10;
	assign unit_d    = unit_full[3:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1.slot  <= slot_q;
			ctl_s1.blink <= blink_phase;
			ctl_s1.leds  <= (slot_q == SLOT_GREEN) ? green_leds : red_leds;
			val_s1       <= (slot_q < SLOT_W'(4)) ? upper_value : lower_value;

			ctl_s2 <= ctl_s1;
			neg_s2 <= val_s1[VAL_W-1];
			mag_s2 <= val_s1[VAL_W-1] ? VAL_W'(-val_s1) : VAL_W'(val_s1);

			ctl_s3 <= ctl_s2;
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;

			ctl_s4  <= ctl_s3;
			neg_s4  <= neg_s3;
			thou_s4 <= thou_prod[29:25];
			rem_s4  <= rem_full[9:0];

			ctl_s5  <= ctl_s4;
			neg_s5  <= neg_s4;
			thou_s5 <= thou_s4;
			rem_s5  <= rem_s4;
			hun_s5  <= hun_prod[15:12];

			ctl_s6  <= ctl_s5;
			neg_s6  <= neg_s5;
			thou_s6 <= thou_s5;
			hun_s6  <= hun_s5;
			tr_s6   <= tr_full[6:0];

			ctl_s7  <= ctl_s6;
			neg_s7  <= neg_s6;
			thou_s7 <= thou_s6;
			hun_s7  <= hun_s6;
			tr_s7   <= tr_s6;
			ten_s7  <= ten_prod[14:11];

			segments      <= seg_d;
			common_select <= sel_d;
		end
	end

	// thousands index comes straight from the divide step
	always_comb begin
		thou_s3 = thou_prod[29:25];
	end

	always_comb begin
		case (ctl_s7.slot[1:0])
			PLACE_THOU: glyph_d = neg_s7 ? GLYPH_NEG : GLYPH_W'(thou_s7);
			PLACE_HUN:  glyph_d = GLYPH_W'(hun_s7);
			PLACE_TEN:  glyph_d = GLYPH_W'(ten_s7);
			PLACE_UNIT: glyph_d = GLYPH_W'(unit_d);
			default:    glyph_d = GLYPH_NEG;
		endcase
	end

	always_comb begin
		seg_d = SEG_BLANK;
		sel_d = '0;
		if (!ctl_s7.slot[SLOT_W-1]) begin
			seg_d = seg_lookup(glyph_d);
			if (ctl_s7.slot[2:0] == ~blink_position_q && blink_enable_q && ctl_s7.blink) begin
				seg_d = SEG_BLANK;
			end
			sel_d = SEL_W'(1) << ctl_s7.slot;
		end else if (ctl_s7.slot == SLOT_RED || ctl_s7.slot == SLOT_GREEN) begin
			seg_d = ctl_s7.leds;
			sel_d = SEL_W'(1) << ctl_s7.slot;
		end
	end

endmodule

>>> design/dvss_checker.sv
// dvss_checker: port level assertions for the scanner top level, bound in
// below. Depends on dvss_pkg.

module dvss_checker
	import dvss_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              pwrite,
	input logic [2:0]        paddr,
	input logic [31:0]       prdata,
	input logic              out_valid,
	input logic              out_ready,
	input logic [SEG_W-1:0]  segments,
	input logic [SEL_W-1:0]  common_select
);

	// a stalled result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(common_select))
		else $error("common select not one-hot");

	// no common driven means a blank slot
	a_blank_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && common_select == '0 |-> segments == SEG_BLANK)
		else $error("unselected slot not blank");

	a_enable_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[2] == REG_BLINK_ENABLE |-> prdata[31:1] == '0)
		else $error("blink enable read has stray bits");

endmodule

bind dual_value_seven_segment_scanner_unit dvss_checker u_dvss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.psel          (psel),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.prdata        (prdata),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.segments      (segments),
	.common_select (common_select)
);
